/* hdl/taylor_cosine_evaluator_macros.svh */
// ----------------------------------------------------------------------------
// taylor_cosine_evaluator_macros
// Assertion macros shared by the checker of the cosine evaluator.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_COSINE_EVALUATOR_MACROS_SVH
`define TAYLOR_COSINE_EVALUATOR_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define TCE_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define TCE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* hdl/tce_pkg.sv */
// ----------------------------------------------------------------------------
// tce_pkg
// Types, widths and the rounding multiplier of the cosine evaluator.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int FRAC_BITS = 30;
    localparam int ANGLE_W   = 31;
    localparam int COS_W     = 32;
    localparam int TERM_W    = 31;
    localparam int SUM_W     = 36;
    localparam int N_W       = 6;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_TERMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

    localparam logic [4:0]        MAX_TERMS_RESET = 5'd8;
    localparam logic [CFG_W-1:0]  TOLERANCE_RESET = 31'd1074;
    localparam logic [TERM_W-1:0] ONE             = TERM_W'(1) << FRAC_BITS;

    // one item as it travels down the pipeline
    typedef struct packed {
        logic              valid;
        logic [N_W-1:0]    n;
        logic [TERM_W-1:0] x2;
        logic [TERM_W-1:0] term;
        logic [SUM_W-1:0]  pos;
        logic [SUM_W-1:0]  neg;
    } item_t;

    // product of two values at most 1.0, rounded half up
    function automatic logic [TERM_W-1:0] fx_mul(
        input logic [TERM_W-1:0] a,
        input logic [TERM_W-1:0] b
    );
        logic [2*TERM_W-1:0] p;
        begin
            p = a * b;
            p = p + ((2*TERM_W)'(1) << (FRAC_BITS - 1));
            fx_mul = p[FRAC_BITS +: TERM_W];
        end
    endfunction

endpackage

/* hdl/taylor_cosine_evaluator.sv */
// ----------------------------------------------------------------------------
// taylor_cosine_evaluator
// Truncated Maclaurin-series cosine of a signed Q1.30 angle.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry angle. Output channel:
// out_valid / out_stall carry cosine (Q2.30) and error_not_met, which is
// set when the first omitted term exceeds the tolerance register.
// Config: cfg_write with cfg_index 0 sets max_terms, index 1 sets
// tolerance; write only while no transfer is in flight.
// Stages: the magnitude and square registers, then per term an accumulate
// stage and a reciprocal stage (one multiplier each), then the output
// register. One item enters per cycle whatever max_terms is, unless stalled.
// Reset empties the pipeline and loads max_terms = 8, tolerance = 1074.
// A stalled output holds its transfer and freezes the whole pipeline;
// in_stall is raised in the same cycle so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module taylor_cosine_evaluator #(
    parameter int MAX_TERMS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tce_pkg::ANGLE_W-1:0]  angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tce_pkg::COS_W-1:0]    cosine,
    output logic                                error_not_met,
    input  logic                                cfg_write,
    input  logic [tce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]           cfg_data
);

    logic [4:0]                  max_terms_reg;
    logic [tce_pkg::CFG_W-1:0]   tolerance_reg;
    logic [tce_pkg::N_W-1:0]     n_sat;
    logic                        en;
    tce_pkg::item_t              chain [0:MAX_TERMS];
    logic [tce_pkg::SUM_W-1:0]   sum;
    logic                        out_valid_reg;
    logic [tce_pkg::COS_W-1:0]   cosine_reg;
    logic [tce_pkg::COS_W-1:0]   cosine_next;
    logic                        error_reg;
    logic                        error_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_terms_reg <= tce_pkg::MAX_TERMS_RESET;
            tolerance_reg <= tce_pkg::TOLERANCE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tce_pkg::REG_MAX_TERMS: max_terms_reg <= cfg_data[4:0];
                tce_pkg::REG_TOLERANCE: tolerance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // term count clipped to the pipeline depth
    assign n_sat = (tce_pkg::N_W'(max_terms_reg) > tce_pkg::N_W'(MAX_TERMS))
                 ? tce_pkg::N_W'(MAX_TERMS) : tce_pkg::N_W'(max_terms_reg);

    // whole pipeline advances unless the output transfer is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    tce_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .angle    (angle),
        .n        (n_sat),
        .item     (chain[0])
    );

    // one stage pair per series term
    for (genvar k = 1; k <= MAX_TERMS; k++)
    begin : g_term
        tce_term #(.K(k)) u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_item  (chain[k-1]),
            .out_item (chain[k])
        );
    end

    // difference, saturation and remainder check
    always_comb
    begin
        if (chain[MAX_TERMS].pos >= chain[MAX_TERMS].neg)
            sum = chain[MAX_TERMS].pos - chain[MAX_TERMS].neg;
        else
            sum = '0;
        if (sum > tce_pkg::SUM_W'(32'h7FFF_FFFF))
            cosine_next = 32'h7FFF_FFFF;
        else
            cosine_next = sum[tce_pkg::COS_W-1:0];
        error_next = chain[MAX_TERMS].term > tolerance_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain[MAX_TERMS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cosine_reg <= cosine_next;
            error_reg  <= error_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cosine        = cosine_reg;
    assign error_not_met = error_reg;

endmodule

/* hdl/tce_square.sv */
// ----------------------------------------------------------------------------
// tce_square
// Front stages: angle magnitude, then its rounded square.
// ----------------------------------------------------------------------------
module tce_square (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [tce_pkg::ANGLE_W-1:0] angle,
    input  logic [tce_pkg::N_W-1:0]           n,
    output tce_pkg::item_t                    item
);

    logic                        v1_reg;
    logic [tce_pkg::N_W-1:0]     n1_reg;
    logic [tce_pkg::TERM_W-1:0]  mag_reg;
    logic [tce_pkg::TERM_W-1:0]  mag_next;
    tce_pkg::item_t              item_reg;
    tce_pkg::item_t              item_next;

    // magnitude of the raw angle bits
    always_comb
    begin
        if (angle[tce_pkg::ANGLE_W-1])
            mag_next = tce_pkg::TERM_W'(~angle) + tce_pkg::TERM_W'(1);
        else
            mag_next = tce_pkg::TERM_W'(angle);
    end

    // square and seed of the series
    always_comb
    begin
        item_next.valid = v1_reg;
        item_next.n     = n1_reg;
        item_next.x2    = tce_pkg::fx_mul(mag_reg, mag_reg);
        item_next.term  = tce_pkg::ONE;
        item_next.pos   = '0;
        item_next.neg   = '0;
    end

    // stage registers, valid bits travel with the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            n1_reg   <= '0;
            mag_reg  <= '0;
            item_reg <= '0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            n1_reg   <= n;
            mag_reg  <= mag_next;
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

/* hdl/tce_term.sv */
// ----------------------------------------------------------------------------
// tce_term
// One series term: accumulate, multiply by x^2, multiply by the reciprocal.
// ----------------------------------------------------------------------------
module tce_term #(
    parameter int K = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  tce_pkg::item_t in_item,
    output tce_pkg::item_t out_item
);

    localparam int D     = (2*K - 1) * (2*K);
    localparam int RECIP = ((1 << tce_pkg::FRAC_BITS) + D / 2) / D;
    localparam logic [tce_pkg::TERM_W-1:0] RECIP_V = tce_pkg::TERM_W'(RECIP);

    tce_pkg::item_t a_reg;
    tce_pkg::item_t a_next;
    tce_pkg::item_t b_reg;
    tce_pkg::item_t b_next;
    logic           act_a;
    logic           act_b;

    assign act_a = in_item.n >= tce_pkg::N_W'(K);
    assign act_b = a_reg.n >= tce_pkg::N_W'(K);

    // accumulate with alternating sign, then times x^2
    always_comb
    begin
        a_next = in_item;
        if (act_a)
        begin
            if (K % 2 == 1)
                a_next.pos = in_item.pos + tce_pkg::SUM_W'(in_item.term);
            else
                a_next.neg = in_item.neg + tce_pkg::SUM_W'(in_item.term);
            a_next.term = tce_pkg::fx_mul(in_item.term, in_item.x2);
        end
    end

    // times the reciprocal of (2k-1)(2k)
    always_comb
    begin
        b_next = a_reg;
        if (act_b)
            b_next.term = tce_pkg::fx_mul(a_reg.term, RECIP_V);
    end

    // stage registers, valid bits travel with the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_item = b_reg;

endmodule

/* hdl/tce_checker.sv */
// ----------------------------------------------------------------------------
// tce_checker
// Port-level checks of the cosine evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "taylor_cosine_evaluator_macros.svh"

module tce_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [tce_pkg::COS_W-1:0]   cosine,
    input logic                               error_not_met
);

    // held output transfer keeps its payload
    `TCE_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(cosine) && $stable(error_not_met))

    // input is stalled exactly when the output transfer is held
    `TCE_ASSERT_NOW(a_backpressure, clk, rst_n, 1'b1, in_stall == (out_valid && out_stall))

    // the series sum is never negative
    `TCE_ASSERT_NOW(a_nonneg, clk, rst_n, out_valid, !cosine[tce_pkg::COS_W-1])

endmodule

bind taylor_cosine_evaluator tce_checker u_tce_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cosine        (cosine),
    .error_not_met (error_not_met)
);
